// File: hdl/lsbse_pkg.sv
// Shared types, constants and the end-tag table for the LSB embed/extract unit.
// No dependencies; used by every file under hdl.
package lsbse_pkg;

	localparam int TAG_LENGTH_DEF  = 7;
	localparam int COUNT_WIDTH_DEF = 32;
	localparam int CAP_W           = 32;
	localparam int SLOT_W          = 4;

	localparam logic [2:0] ST_EMBEDDED = 3'd0;
	localparam logic [2:0] ST_PASSED   = 3'd1;
	localparam logic [2:0] ST_NOSPACE  = 3'd2;
	localparam logic [2:0] ST_BYTE     = 3'd3;
	localparam logic [2:0] ST_LAST     = 3'd4;
	localparam logic [2:0] ST_EMPTY    = 3'd5;
	localparam logic [2:0] ST_NOTAG    = 3'd6;

	localparam logic REG_MODE     = 1'b0;
	localparam logic REG_CAPACITY = 1'b1;

	localparam logic MODE_EMBED   = 1'b0;
	localparam logic MODE_EXTRACT = 1'b1;

	typedef struct packed {
		logic [7:0] pix0;
		logic [7:0] pix1;
		logic [7:0] pix2;
		logic [7:0] pix3;
		logic [7:0] pix4;
		logic [7:0] pix5;
		logic [7:0] pix6;
		logic [7:0] pix7;
		logic [7:0] secret_byte;
		logic       secret_last;
	} item_t;

	typedef struct packed {
		logic [7:0] out0;
		logic [7:0] out1;
		logic [7:0] out2;
		logic [7:0] out3;
		logic [7:0] out4;
		logic [7:0] out5;
		logic [7:0] out6;
		logic [7:0] out7;
		logic [7:0] recovered_byte;
		logic [2:0] status;
	} result_t;

	// history row control
	typedef struct packed {
		logic clear;
		logic shift;
	} chain_ctl_t;

	// "||EOF||", zero beyond the seventh slot
	function automatic logic [7:0] tag_byte(input logic [SLOT_W-1:0] idx);
		logic [7:0] b;
		case (idx)
			4'd0:    b = 8'h7C;
			4'd1:    b = 8'h7C;
			4'd2:    b = 8'h45;
			4'd3:    b = 8'h4F;
			4'd4:    b = 8'h46;
			4'd5:    b = 8'h7C;
			4'd6:    b = 8'h7C;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

// File: hdl/lsb_stego_embed_extract_unit.sv
// Top level of the LSB steganography embed/extract unit with end tag.
// Depends on lsbse_pkg, lsbse_chain (and through it lsbse_cell).
//
//  channel  | signals                              | payload
//  ---------+--------------------------------------+-------------------------
//  item     | item_valid / item_ready              | item   (lsbse_pkg::item_t)
//  result   | result_valid / result_ready          | result (lsbse_pkg::result_t)
//  config   | cfg_we, cfg_index                    | cfg_wdata (32 bits)
//
// One item per cycle while item_ready is high; its result, if any, appears in the cycle after acceptance.
// The sustained rate is set by the single output register, which frees as it is taken.
// item_ready drops only while a result is held and result_ready is low.
// Reset (arst_n low) clears mode, capacity and all stream state; any register
// write also restarts the stream state.
module lsb_stego_embed_extract_unit #(
	parameter int TAG_LENGTH  = lsbse_pkg::TAG_LENGTH_DEF,
	parameter int COUNT_WIDTH = lsbse_pkg::COUNT_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [lsbse_pkg::CAP_W-1:0]   cfg_wdata,
	input  logic                          item_valid,
	output logic                          item_ready,
	input  lsbse_pkg::item_t              item,
	output logic                          result_valid,
	input  logic                          result_ready,
	output lsbse_pkg::result_t            result
);
	import lsbse_pkg::*;

	localparam int BS_W  = $clog2(TAG_LENGTH + 2);
	localparam int TP_W  = $clog2(TAG_LENGTH + 1);
	localparam int CMP_W = (COUNT_WIDTH + 1 > CAP_W) ? COUNT_WIDTH + 1 : CAP_W;

	logic                   mode_q;
	logic [CAP_W-1:0]       capacity_q;
	logic [COUNT_WIDTH-1:0] pixel_count_q;
	logic [BS_W-1:0]        bytes_seen_q;
	logic [TP_W-1:0]        tag_phase_q;
	logic                   finished_q;
	logic                   failed_q;
	logic                   result_valid_q;
	result_t                result_q;

	logic                   accept;
	logic                   room;
	logic [COUNT_WIDTH:0]   count_sum;
	logic [7:0]             embed_val;
	logic [7:0]             ext_byte;
	logic [7:0]             oldest;
	logic                   match_nxt;
	logic                   full;
	logic                   tag_hit;
	logic [BS_W-1:0]        bytes_seen_nxt;
	logic                   has_result;
	logic                   do_embed;
	logic                   do_extract;
	logic                   set_failed;
	result_t                res_d;
	chain_ctl_t             chain_ctl;

	assign accept     = item_valid && item_ready;
	assign item_ready = !result_valid_q || result_ready;

	assign count_sum = {1'b0, pixel_count_q} + (COUNT_WIDTH + 1)'(8);
	assign room      = CMP_W'(count_sum) <= CMP_W'(capacity_q);

	assign embed_val = (tag_phase_q == '0) ? item.secret_byte
		: tag_byte(SLOT_W'(tag_phase_q - TP_W'(1)));

	assign ext_byte = {item.pix7[0], item.pix6[0], item.pix5[0], item.pix4[0],
		item.pix3[0], item.pix2[0], item.pix1[0], item.pix0[0]};

	assign full           = bytes_seen_q >= BS_W'(TAG_LENGTH);
	assign bytes_seen_nxt = (bytes_seen_q == BS_W'(TAG_LENGTH + 1)) ? bytes_seen_q
		: bytes_seen_q + BS_W'(1);
	assign tag_hit        = match_nxt && (bytes_seen_nxt >= BS_W'(TAG_LENGTH));

	always_comb begin
		res_d      = '{out0: item.pix0, out1: item.pix1, out2: item.pix2, out3: item.pix3,
			out4: item.pix4, out5: item.pix5, out6: item.pix6, out7: item.pix7,
			recovered_byte: 8'h00, status: ST_PASSED};
		has_result = 1'b0;
		do_embed   = 1'b0;
		do_extract = 1'b0;
		set_failed = 1'b0;
		if (mode_q == MODE_EMBED) begin
			has_result = 1'b1;
			if (finished_q) begin
				res_d.status = ST_PASSED;
			end else if (failed_q || !room) begin
				res_d.status = ST_NOSPACE;
				set_failed   = 1'b1;
			end else begin
				do_embed     = 1'b1;
				res_d.status = ST_EMBEDDED;
				res_d.out0   = {item.pix0[7:1], embed_val[0]};
				res_d.out1   = {item.pix1[7:1], embed_val[1]};
				res_d.out2   = {item.pix2[7:1], embed_val[2]};
				res_d.out3   = {item.pix3[7:1], embed_val[3]};
				res_d.out4   = {item.pix4[7:1], embed_val[4]};
				res_d.out5   = {item.pix5[7:1], embed_val[5]};
				res_d.out6   = {item.pix6[7:1], embed_val[6]};
				res_d.out7   = {item.pix7[7:1], embed_val[7]};
			end
		end else if (!(finished_q || failed_q)) begin
			if (!room) begin
				has_result   = 1'b1;
				res_d.status = ST_NOTAG;
				set_failed   = 1'b1;
			end else begin
				do_extract = 1'b1;
				if (tag_hit) begin
					has_result = 1'b1;
					if (full) begin
						res_d.status         = ST_LAST;
						res_d.recovered_byte = oldest;
					end else begin
						res_d.status = ST_EMPTY;
					end
				end else if (full) begin
					has_result           = 1'b1;
					res_d.status         = ST_BYTE;
					res_d.recovered_byte = oldest;
				end
			end
		end
	end

	assign chain_ctl.clear = cfg_we;
	assign chain_ctl.shift = accept && do_extract;

	lsbse_chain #(
		.TAG_LENGTH(TAG_LENGTH)
	) u_chain (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (chain_ctl),
		.byte_in  (ext_byte),
		.oldest   (oldest),
		.match_nxt(match_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= MODE_EMBED;
			capacity_q    <= '0;
			pixel_count_q <= '0;
			bytes_seen_q  <= '0;
			tag_phase_q   <= '0;
			finished_q    <= 1'b0;
			failed_q      <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MODE:     mode_q     <= cfg_wdata[0];
				REG_CAPACITY: capacity_q <= cfg_wdata;
				default:      mode_q     <= mode_q;
			endcase
			pixel_count_q <= '0;
			bytes_seen_q  <= '0;
			tag_phase_q   <= '0;
			finished_q    <= 1'b0;
			failed_q      <= 1'b0;
		end else if (accept) begin
			if (set_failed) begin
				failed_q <= 1'b1;
			end
			if (do_embed || do_extract) begin
				pixel_count_q <= pixel_count_q + COUNT_WIDTH'(8);
			end
			if (do_embed) begin
				if (tag_phase_q == '0) begin
					if (item.secret_last) begin
						tag_phase_q <= TP_W'(1);
					end
				end else if (tag_phase_q == TP_W'(TAG_LENGTH)) begin
					tag_phase_q <= '0;
					finished_q  <= 1'b1;
				end else begin
					tag_phase_q <= tag_phase_q + TP_W'(1);
				end
			end
			if (do_extract) begin
				bytes_seen_q <= bytes_seen_nxt;
				if (tag_hit) begin
					finished_q <= 1'b1;
				end
			end
		end
	end

	// output register: parts the result side from the item side
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (accept) begin
			result_valid_q <= has_result;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && has_result) begin
			result_q <= res_d;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

// File: hdl/lsbse_cell.sv
// One history cell: holds an extracted byte, loads its input byte on a shift
// and flags whether the byte it is loading equals its tag character. Uses lsbse_pkg.
module lsbse_cell #(
	parameter logic [7:0] TAG_CHAR = 8'h00
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  lsbse_pkg::chain_ctl_t ctl,
	input  logic [7:0]            d,
	output logic [7:0]            q,
	output logic                  hit
);
	import lsbse_pkg::*;

	logic [7:0] byte_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= '0;
		end else if (ctl.clear) begin
			byte_q <= '0;
		end else if (ctl.shift) begin
			byte_q <= d;
		end
	end

	assign q   = byte_q;
	assign hit = (d == TAG_CHAR);

endmodule

// File: hdl/lsbse_chain.sv
// Row of TAG_LENGTH history cells, oldest at cell 0, newest byte entering at the top.
// Depends on lsbse_pkg and lsbse_cell.
module lsbse_chain #(
	parameter int TAG_LENGTH = lsbse_pkg::TAG_LENGTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  lsbse_pkg::chain_ctl_t ctl,
	input  logic [7:0]            byte_in,
	output logic [7:0]            oldest,
	output logic                  match_nxt
);
	import lsbse_pkg::*;

	logic [7:0]            q   [TAG_LENGTH];
	logic [TAG_LENGTH-1:0] hit;

	for (genvar i = 0; i < TAG_LENGTH; i++) begin : g_cell
		logic [7:0] d;
		if (i == TAG_LENGTH - 1) begin : g_top
			assign d = byte_in;
		end else begin : g_mid
			assign d = q[i+1];
		end
		lsbse_cell #(
			.TAG_CHAR(tag_byte(SLOT_W'(i)))
		) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.ctl   (ctl),
			.d     (d),
			.q     (q[i]),
			.hit   (hit[i])
		);
	end

	assign oldest    = q[0];
	// tag check on the row as it will stand after this shift
	assign match_nxt = &hit;

endmodule

// File: hdl/lsbse_checker.sv
// Port-level checks for lsb_stego_embed_extract_unit, attached by bind.
// Depends on lsbse_pkg and the top level's port list.
module lsbse_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               item_ready,
	input logic               result_valid,
	input logic               result_ready,
	input lsbse_pkg::result_t result
);
	import lsbse_pkg::*;

	// a held transaction keeps its payload
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	// an empty output register never holds back the item side
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> item_ready)
		else $error("item_ready low with no result pending");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.status <= ST_NOTAG)
		else $error("status code out of range");

	// only byte reports carry a recovered byte
	a_recovered_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !(result.status == ST_BYTE || result.status == ST_LAST)
		|-> result.recovered_byte == 8'h00)
		else $error("recovered byte set on a non-byte status");

endmodule

bind lsb_stego_embed_extract_unit lsbse_checker u_lsbse_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.item_ready  (item_ready),
	.result_valid(result_valid),
	.result_ready(result_ready),
	.result      (result)
);
